// ----- design/v3alu_pkg.sv -----
// Shared types, opcodes and saturation helper for the vector ALU.
`default_nettype none

package v3alu_pkg;

  localparam int unsigned FRAC_BITS_DEFAULT = 16;
  localparam int unsigned SQRT_STEPS        = 32;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_CROSS = 3'd3,
    OP_DOT   = 3'd4,
    OP_MAGSQ = 3'd5,
    OP_MAG   = 3'd6,
    OP_NORM  = 3'd7
  } v3alu_op_e;

  typedef struct packed {
    logic        [2:0]  opcode;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] scale_factor;
  } v3alu_in_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] scalar_out;
    logic               overflow;
  } v3alu_out_t;

  // Partial result that rides along the sqrt and divide pipes.
  typedef struct packed {
    v3alu_op_e        op;
    logic [31:0]      rx;
    logic [31:0]      ry;
    logic [31:0]      rz;
    logic [31:0]      sc;
    logic             ov;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
  } v3alu_carry_t;

  typedef struct packed {
    logic        ov;
    logic [31:0] val;
  } v3alu_sat_t;

  function automatic v3alu_sat_t sat32(input logic signed [65:0] v);
    v3alu_sat_t r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r.ov  = 1'b1;
      r.val = 32'h7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      r.ov  = 1'b1;
      r.val = 32'h8000_0000;
    end else begin
      r.ov  = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/v3alu_front.sv -----
// Front pipe: input register, product stage, sum/shift/saturate stage.
`default_nettype none

module v3alu_front import v3alu_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic         in_valid_i,
  input  wire v3alu_in_t    in_req_i,
  output logic              out_valid_o,
  output logic [63:0]       out_s_o,
  output v3alu_carry_t      out_carry_o
);

  // stage 0: input register
  logic      vld0_q;
  v3alu_in_t req0_q;

  // stage 1: products and add/sub
  logic                vld1_q;
  v3alu_op_e           op1_q;
  logic signed [63:0]  prod_q [6];
  logic signed [63:0]  prod_d [6];
  logic        [31:0]  as_q   [3];
  logic        [31:0]  as_d   [3];
  logic                as_ov_q, as_ov_d;
  logic signed [31:0]  a1_q   [3];

  // stage 2: sums
  logic         vld2_q;
  logic [63:0]  s2_q, s2_d;
  v3alu_carry_t carry2_q, carry2_d;

  v3alu_op_e          op0;
  logic signed [31:0] av [3];
  logic signed [31:0] bv [3];
  logic signed [31:0] ma [6];
  logic signed [31:0] mb [6];
  v3alu_sat_t         as_sat [3];

  always_comb begin
    op0   = v3alu_op_e'(req0_q.opcode);
    av[0] = req0_q.ax;
    av[1] = req0_q.ay;
    av[2] = req0_q.az;
    bv[0] = req0_q.bx;
    bv[1] = req0_q.by;
    bv[2] = req0_q.bz;
    for (int i = 0; i < 6; i++) begin
      ma[i] = '0;
      mb[i] = '0;
    end
    unique case (op0)
      OP_ADD, OP_SUB: begin
      end
      OP_SCALE: begin
        for (int l = 0; l < 3; l++) begin
          ma[2*l] = av[l];
          mb[2*l] = req0_q.scale_factor;
        end
      end
      OP_CROSS: begin
        ma[0] = av[1]; mb[0] = bv[2];
        ma[1] = av[2]; mb[1] = bv[1];
        ma[2] = av[2]; mb[2] = bv[0];
        ma[3] = av[0]; mb[3] = bv[2];
        ma[4] = av[0]; mb[4] = bv[1];
        ma[5] = av[1]; mb[5] = bv[0];
      end
      OP_DOT: begin
        for (int l = 0; l < 3; l++) begin
          ma[l] = av[l];
          mb[l] = bv[l];
        end
      end
      OP_MAGSQ, OP_MAG, OP_NORM: begin
        for (int l = 0; l < 3; l++) begin
          ma[l] = av[l];
          mb[l] = av[l];
        end
      end
    endcase
    for (int i = 0; i < 6; i++) begin
      prod_d[i] = ma[i] * mb[i];
    end
    as_ov_d = 1'b0;
    for (int l = 0; l < 3; l++) begin
      if (op0 == OP_SUB) begin
        as_sat[l] = sat32(66'(av[l]) - 66'(bv[l]));
      end else begin
        as_sat[l] = sat32(66'(av[l]) + 66'(bv[l]));
      end
      as_d[l] = as_sat[l].val;
      as_ov_d = as_ov_d | as_sat[l].ov;
    end
  end

  logic signed [65:0] dif [3];
  logic signed [65:0] sum3;
  v3alu_sat_t         vsat [3];
  v3alu_sat_t         ssat;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      // scale leaves the odd products at zero, so one form serves both
      dif[l]  = 66'(prod_q[2*l]) - 66'(prod_q[2*l+1]);
      vsat[l] = sat32(dif[l] >>> FRAC_BITS);
    end
    sum3 = 66'(prod_q[0]) + 66'(prod_q[1]) + 66'(prod_q[2]);
    ssat = sat32(sum3 >>> FRAC_BITS);
    s2_d = 64'(prod_q[0]) + 64'(prod_q[1]) + 64'(prod_q[2]);

    carry2_d    = '0;
    carry2_d.op = op1_q;
    for (int l = 0; l < 3; l++) begin
      carry2_d.neg[l] = a1_q[l][31];
      carry2_d.mag[l] = a1_q[l][31] ? 32'(-33'(a1_q[l])) : 32'(a1_q[l]);
    end
    unique case (op1_q)
      OP_ADD, OP_SUB: begin
        carry2_d.rx = as_q[0];
        carry2_d.ry = as_q[1];
        carry2_d.rz = as_q[2];
        carry2_d.ov = as_ov_q;
      end
      OP_SCALE, OP_CROSS: begin
        carry2_d.rx = vsat[0].val;
        carry2_d.ry = vsat[1].val;
        carry2_d.rz = vsat[2].val;
        carry2_d.ov = vsat[0].ov | vsat[1].ov | vsat[2].ov;
      end
      OP_DOT, OP_MAGSQ: begin
        carry2_d.sc = ssat.val;
        carry2_d.ov = ssat.ov;
      end
      OP_MAG, OP_NORM: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld0_q <= in_valid_i;
      vld1_q <= vld0_q;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req0_q   <= in_req_i;
      op1_q    <= op0;
      prod_q   <= prod_d;
      as_q     <= as_d;
      as_ov_q  <= as_ov_d;
      a1_q     <= av;
      s2_q     <= s2_d;
      carry2_q <= carry2_d;
    end
  end

  assign out_valid_o = vld2_q;
  assign out_s_o     = s2_q;
  assign out_carry_o = carry2_q;

endmodule

`default_nettype wire

// ----- design/v3alu_sqrt.sv -----
// Integer square root, one result bit per pipeline stage.
`default_nettype none

module v3alu_sqrt import v3alu_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          in_valid_i,
  input  wire logic [63:0]   in_s_i,
  input  wire v3alu_carry_t  in_carry_i,
  output logic               out_valid_o,
  output logic [31:0]        out_root_o,
  output v3alu_carry_t       out_carry_o
);

  logic [SQRT_STEPS-1:0] vld_q;
  logic [63:0]           rem_q   [SQRT_STEPS];
  logic [63:0]           res_q   [SQRT_STEPS];
  v3alu_carry_t          carry_q [SQRT_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [63:0] StepBit = 64'(1) << (62 - 2 * i);
    logic         vld_in;
    logic [63:0]  rem_in, res_in, trial, rem_d, res_d;
    v3alu_carry_t carry_in;

    if (i == 0) begin : g_first
      assign vld_in   = in_valid_i;
      assign rem_in   = in_s_i;
      assign res_in   = '0;
      assign carry_in = in_carry_i;
    end else begin : g_next
      assign vld_in   = vld_q[i-1];
      assign rem_in   = rem_q[i-1];
      assign res_in   = res_q[i-1];
      assign carry_in = carry_q[i-1];
    end

    always_comb begin
      trial = res_in + StepBit;
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        res_d = (res_in >> 1) + StepBit;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]   <= rem_d;
        res_q[i]   <= res_d;
        carry_q[i] <= carry_in;
      end
    end
  end

  assign out_valid_o = vld_q[SQRT_STEPS-1];
  assign out_root_o  = res_q[SQRT_STEPS-1][31:0];
  assign out_carry_o = carry_q[SQRT_STEPS-1];

endmodule

`default_nettype wire

// ----- design/v3alu_div.sv -----
// Three-lane restoring divider for normalize, one quotient bit per stage.
`default_nettype none

module v3alu_div import v3alu_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          in_valid_i,
  input  wire logic [31:0]   in_root_i,
  input  wire v3alu_carry_t  in_carry_i,
  output logic               out_valid_o,
  output logic [31:0]        out_root_o,
  output logic [2:0][FRAC_BITS:0] out_quo_o,
  output v3alu_carry_t       out_carry_o
);

  localparam int unsigned Steps = FRAC_BITS + 1;

  logic [Steps-1:0]          vld_q;
  logic [2:0][32:0]          rem_q   [Steps];
  logic [2:0][FRAC_BITS:0]   quo_q   [Steps];
  logic [31:0]               root_q  [Steps];
  v3alu_carry_t              carry_q [Steps];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic                    vld_in;
    logic [2:0][32:0]        rem_in, rem_d;
    logic [2:0][FRAC_BITS:0] quo_in, quo_d;
    logic [31:0]             root_in;
    v3alu_carry_t            carry_in;

    if (k == 0) begin : g_first
      assign vld_in   = in_valid_i;
      assign root_in  = in_root_i;
      assign carry_in = in_carry_i;
      assign quo_in   = '0;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = {1'b0, in_carry_i.mag[l]};
      end
    end else begin : g_next
      assign vld_in   = vld_q[k-1];
      assign root_in  = root_q[k-1];
      assign carry_in = carry_q[k-1];
      assign quo_in   = quo_q[k-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = {rem_q[k-1][l][31:0], 1'b0};
      end
    end

    always_comb begin
      quo_d = quo_in;
      for (int l = 0; l < 3; l++) begin
        if (rem_in[l] >= {1'b0, root_in}) begin
          rem_d[l]                = rem_in[l] - {1'b0, root_in};
          quo_d[l][FRAC_BITS - k] = 1'b1;
        end else begin
          rem_d[l] = rem_in[l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]   <= rem_d;
        quo_q[k]   <= quo_d;
        root_q[k]  <= root_in;
        carry_q[k] <= carry_in;
      end
    end
  end

  assign out_valid_o = vld_q[Steps-1];
  assign out_root_o  = root_q[Steps-1];
  assign out_quo_o   = quo_q[Steps-1];
  assign out_carry_o = carry_q[Steps-1];

endmodule

`default_nettype wire

// ----- design/vector3_alu.sv -----
// Top level of the three-component fixed-point vector ALU.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------
//   in      | to ALU    | in_valid_i/in_stall_o | in_req_i   (v3alu_in_t)
//   out     | from ALU  | out_valid_o/out_stall_i | out_req_o (v3alu_out_t)
//
// One request enters per cycle while in_stall_o is low. Every opcode takes
// the same path: 3 front stages (input, multiply, sum), 32 square root stages,
// FRAC_BITS + 1 divide stages and the output register.
// Reset clears only the valid bits; data registers are left as they are.
// A stalled output parks the next result in a skid register; while it is
// full in_stall_o is high and the whole pipe holds.
`default_nettype none

module vector3_alu import v3alu_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire v3alu_in_t   in_req_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output v3alu_out_t       out_req_o
);

  logic en;

  logic         fr_valid;
  logic [63:0]  fr_s;
  v3alu_carry_t fr_carry;

  logic         sq_valid;
  logic [31:0]  sq_root;
  v3alu_carry_t sq_carry;

  logic                    dv_valid;
  logic [31:0]             dv_root;
  logic [2:0][FRAC_BITS:0] dv_quo;
  v3alu_carry_t            dv_carry;

  logic       out_valid_q, skid_valid_q;
  v3alu_out_t out_q, skid_q, res;
  logic       out_ready, push;

  // whole pipe advances unless the skid register holds a result
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  v3alu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .out_valid_o (fr_valid),
    .out_s_o     (fr_s),
    .out_carry_o (fr_carry)
  );

  v3alu_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (fr_valid),
    .in_s_i      (fr_s),
    .in_carry_i  (fr_carry),
    .out_valid_o (sq_valid),
    .out_root_o  (sq_root),
    .out_carry_o (sq_carry)
  );

  v3alu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (sq_valid),
    .in_root_i   (sq_root),
    .in_carry_i  (sq_carry),
    .out_valid_o (dv_valid),
    .out_root_o  (dv_root),
    .out_quo_o   (dv_quo),
    .out_carry_o (dv_carry)
  );

  // Final select. Magnitude saturates above 2^31-1. Normalize quotients are
  // at most 2^FRAC_BITS, so they never saturate; a zero root gives zeros.
  logic [31:0] nv [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      nv[l] = dv_carry.neg[l] ? -32'(dv_quo[l]) : 32'(dv_quo[l]);
    end
    res.rx         = dv_carry.rx;
    res.ry         = dv_carry.ry;
    res.rz         = dv_carry.rz;
    res.scalar_out = dv_carry.sc;
    res.overflow   = dv_carry.ov;
    if (dv_carry.op == OP_MAG) begin
      if (dv_root[31]) begin
        res.scalar_out = 32'h7FFF_FFFF;
        res.overflow   = 1'b1;
      end else begin
        res.scalar_out = dv_root;
      end
    end else if (dv_carry.op == OP_NORM) begin
      if (dv_root != '0) begin
        res.rx = nv[0];
        res.ry = nv[1];
        res.rz = nv[2];
      end
    end
  end

  assign out_ready = !out_valid_q || !out_stall_i;
  assign push      = dv_valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_ready) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (push) begin
        if (out_ready) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_ready) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

`default_nettype wire

// ----- design/v3alu_checker.sv -----
// Port-level checks for the vector ALU, bound to the top level.
`default_nettype none

module v3alu_checker import v3alu_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire v3alu_in_t  in_req_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire v3alu_out_t out_req_o
);

  logic in_seen;
  assign in_seen = in_valid_i || (in_req_i.opcode == in_req_i.opcode);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

  // input back-pressure only follows a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_seen && in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output stall");

  // vector and scalar results never both nonzero
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_req_o.rx != '0 || out_req_o.ry != '0 || out_req_o.rz != '0)
    |-> out_req_o.scalar_out == '0)
    else $error("vector and scalar result both set");

  // overflow means some field sits at a saturation bound
  a_ov_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.overflow |->
      (out_req_o.rx == 32'h7FFF_FFFF || out_req_o.rx == 32'h8000_0000 ||
       out_req_o.ry == 32'h7FFF_FFFF || out_req_o.ry == 32'h8000_0000 ||
       out_req_o.rz == 32'h7FFF_FFFF || out_req_o.rz == 32'h8000_0000 ||
       out_req_o.scalar_out == 32'h7FFF_FFFF ||
       out_req_o.scalar_out == 32'h8000_0000))
    else $error("overflow without saturated field");

endmodule

bind vector3_alu v3alu_checker u_v3alu_checker (.*);

`default_nettype wire
